>>> sv/pmca_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pmca_pkg
// Shared types and constants of the polygon centroid accumulator.
// -----------------------------------------------------------------------------
package pmca_pkg;

    localparam int unsigned COORD_W   = 16;
    localparam int unsigned CROSS_W   = 33;
    localparam int unsigned SUM_W     = 17;
    localparam int unsigned TERM_W    = 50;
    localparam int unsigned CELL_D_W  = 36;
    localparam int unsigned CELL_M_W  = 52;
    localparam int unsigned BODY_D_W  = 52;
    localparam int unsigned BODY_M_W  = 64;
    localparam int unsigned DEN_W     = 54;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned OUT_DATA_W = 88;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SAT  = 2'd2;

    localparam logic KIND_CELL = 1'b0;
    localparam logic KIND_BODY = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_OPEN,
        S_MUL,
        S_CROSS,
        S_MOM,
        S_ACC,
        S_RES,
        S_CHK,
        S_DIVX,
        S_DIVY,
        S_EMIT,
        S_BODY
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_in;
        logic start_cell;
        logic edge_close;
        logic mul_en;
        logic cross_en;
        logic mom_en;
        logic acc_en;
        logic set_prev;
        logic res_setup;
        logic div_start;
        logic div_sel_y;
        logic cap_x;
        logic cap_y;
        logic out_load;
        logic body_add;
        logic cell_clear;
        logic all_clear;
        logic kind;
        logic last;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic in_cell;
        logic close;
        logic mesh;
        logic d_zero;
        logic div_busy;
        logic div_done;
        logic out_room;
    } t_stat;

endpackage

>>> sv/pmca_div.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pmca_div
// Signed 64 by 54 bit restoring divider, one quotient bit per cycle,
// truncating toward zero, with the quotient saturated to 16 bits.
// -----------------------------------------------------------------------------
module pmca_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [pmca_pkg::BODY_M_W-1:0] i_num,
    input  logic signed [pmca_pkg::DEN_W-1:0]    i_den,
    output logic                               o_busy,
    output logic                               o_done,
    output logic signed [pmca_pkg::COORD_W-1:0]  o_quo,
    output logic                               o_sat
);

    logic                             r_busy;
    logic                             r_done;
    logic [5:0]                       r_cnt;
    logic [pmca_pkg::DEN_W-1:0]       r_rem;
    logic [pmca_pkg::BODY_M_W-1:0]    r_quo;
    logic [pmca_pkg::DEN_W-1:0]       r_den;
    logic                             r_neg;

    logic [pmca_pkg::DEN_W:0]         trial;
    logic [pmca_pkg::DEN_W:0]         diff;
    logic                             fits;

    // Trial subtract of the shifted remainder
    always_comb begin
        trial = {r_rem, r_quo[pmca_pkg::BODY_M_W-1]};
        diff  = trial - {1'b0, r_den};
        fits  = (trial >= {1'b0, r_den});
    end

    // Control of the iteration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd63;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Magnitudes and shifting quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num[pmca_pkg::BODY_M_W-1] ? -i_num : i_num;
            r_den <= i_den[pmca_pkg::DEN_W-1] ? -i_den : i_den;
            r_neg <= i_num[pmca_pkg::BODY_M_W-1] ^ i_den[pmca_pkg::DEN_W-1];
        end else if (r_busy) begin
            r_rem <= fits ? diff[pmca_pkg::DEN_W-1:0] : trial[pmca_pkg::DEN_W-1:0];
            r_quo <= {r_quo[pmca_pkg::BODY_M_W-2:0], fits};
        end
    end

    // Apply sign and saturate
    always_comb begin
        if (r_neg) begin
            o_sat = (r_quo > 64'd32768);
            o_quo = o_sat ? 16'sh8000 : -$signed(r_quo[pmca_pkg::COORD_W-1:0]);
        end else begin
            o_sat = (r_quo > 64'd32767);
            o_quo = o_sat ? 16'sh7FFF : $signed(r_quo[pmca_pkg::COORD_W-1:0]);
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule

>>> sv/pmca_datapath.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pmca_datapath
// Vertex registers, shoelace multiply-accumulate stages, cell and body
// accumulators, the shared divider and the result register.
// -----------------------------------------------------------------------------
module pmca_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pmca_pkg::t_cmd            i_cmd,
    output pmca_pkg::t_stat           o_stat,
    input  logic [31:0]               i_in_data,
    input  logic                      i_in_cell_end,
    input  logic                      i_in_mesh_end,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [pmca_pkg::OUT_DATA_W-1:0] o_out_data,
    output logic                      o_out_kind,
    output logic                      o_out_last
);

    logic signed [pmca_pkg::COORD_W-1:0]  r_cur_x, r_cur_y;
    logic signed [pmca_pkg::COORD_W-1:0]  r_first_x, r_first_y;
    logic signed [pmca_pkg::COORD_W-1:0]  r_prev_x, r_prev_y;
    logic                                 r_close, r_mesh, r_inside;
    logic signed [31:0]                   r_p1, r_p2;
    logic signed [pmca_pkg::SUM_W-1:0]    r_sx, r_sy;
    logic signed [pmca_pkg::CROSS_W-1:0]  r_c;
    logic signed [pmca_pkg::TERM_W-1:0]   r_tx, r_ty;
    logic signed [pmca_pkg::CELL_D_W-1:0] r_cell_d;
    logic signed [pmca_pkg::CELL_M_W-1:0] r_cell_mx, r_cell_my;
    logic signed [pmca_pkg::BODY_D_W-1:0] r_body_d;
    logic signed [pmca_pkg::BODY_M_W-1:0] r_body_mx, r_body_my;
    logic signed [pmca_pkg::DEN_W-1:0]    r_den;
    logic signed [pmca_pkg::BODY_D_W-1:0] r_area;
    logic                                 r_zero, r_sat;
    logic signed [pmca_pkg::COORD_W-1:0]  r_cx, r_cy;
    logic                                 r_o_valid;
    logic [pmca_pkg::OUT_DATA_W-1:0]      r_o_data;
    logic                                 r_o_kind, r_o_last;

    logic signed [pmca_pkg::COORD_W-1:0]  ax, ay, bx, by;
    logic signed [pmca_pkg::CELL_D_W:0]   d_sum;
    logic signed [pmca_pkg::CELL_M_W:0]   mx_sum, my_sum;
    logic signed [pmca_pkg::BODY_D_W:0]   bd_sum;
    logic signed [pmca_pkg::BODY_M_W:0]   bx_sum, by_sum;
    logic signed [pmca_pkg::BODY_D_W-1:0] d_sel;
    logic signed [pmca_pkg::DEN_W-1:0]    d_ext;
    logic signed [pmca_pkg::BODY_M_W-1:0] div_num;
    logic                                 div_busy, div_done, div_sat;
    logic signed [pmca_pkg::COORD_W-1:0]  div_quo;
    logic [pmca_pkg::STATUS_W-1:0]        status;
    logic                                 out_room;

    function automatic logic signed [pmca_pkg::CELL_D_W:0] CELL_EXT(
        input logic signed [pmca_pkg::CELL_D_W-1:0] v);
        return 37'(v);
    endfunction

    function automatic logic signed [pmca_pkg::TERM_W-1:0] TERM_W_T(
        input logic signed [pmca_pkg::SUM_W+pmca_pkg::CROSS_W-1:0] v);
        return v[pmca_pkg::TERM_W-1:0];
    endfunction

    // Select the edge endpoints
    always_comb begin
        ax = i_cmd.edge_close ? r_cur_x   : r_prev_x;
        ay = i_cmd.edge_close ? r_cur_y   : r_prev_y;
        bx = i_cmd.edge_close ? r_first_x : r_cur_x;
        by = i_cmd.edge_close ? r_first_y : r_cur_y;
    end

    // Widened sums ahead of saturation
    always_comb begin
        d_sum  = CELL_EXT(r_cell_d) + 37'(r_c);
        mx_sum = 53'(r_cell_mx) + 53'(r_tx);
        my_sum = 53'(r_cell_my) + 53'(r_ty);
        bd_sum = 53'(r_body_d) + 53'(r_cell_d);
        bx_sum = 65'(r_body_mx) + 65'(r_cell_mx);
        by_sum = 65'(r_body_my) + 65'(r_cell_my);
        d_sel  = (i_cmd.kind == pmca_pkg::KIND_BODY) ? r_body_d : 52'(r_cell_d);
        d_ext  = 54'(d_sel);
        div_num = i_cmd.div_sel_y ?
                  ((i_cmd.kind == pmca_pkg::KIND_BODY) ? r_body_my : 64'(r_cell_my)) :
                  ((i_cmd.kind == pmca_pkg::KIND_BODY) ? r_body_mx : 64'(r_cell_mx));
    end

    // Latch the incoming vertex
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cur_x <= i_in_data[15:0];
            r_cur_y <= i_in_data[31:16];
            r_close <= i_in_cell_end | i_in_mesh_end;
            r_mesh  <= i_in_mesh_end;
        end
    end

    // Multiply, cross and moment stages
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_p1 <= ax * by;
            r_p2 <= bx * ay;
            r_sx <= 17'(ax) + 17'(bx);
            r_sy <= 17'(ay) + 17'(by);
        end
        if (i_cmd.cross_en) begin
            r_c <= 33'(r_p1) - 33'(r_p2);
        end
        if (i_cmd.mom_en) begin
            r_tx <= TERM_W_T(r_sx * r_c);
            r_ty <= TERM_W_T(r_sy * r_c);
        end
    end

    // Vertex and accumulator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.all_clear) begin
            r_first_x <= '0;
            r_first_y <= '0;
            r_prev_x  <= '0;
            r_prev_y  <= '0;
            r_inside  <= 1'b0;
            r_cell_d  <= '0;
            r_cell_mx <= '0;
            r_cell_my <= '0;
            r_body_d  <= '0;
            r_body_mx <= '0;
            r_body_my <= '0;
        end else begin
            if (i_cmd.start_cell) begin
                r_first_x <= r_cur_x;
                r_first_y <= r_cur_y;
                r_prev_x  <= r_cur_x;
                r_prev_y  <= r_cur_y;
                r_inside  <= 1'b1;
                r_cell_d  <= '0;
                r_cell_mx <= '0;
                r_cell_my <= '0;
            end
            if (i_cmd.set_prev) begin
                r_prev_x <= r_cur_x;
                r_prev_y <= r_cur_y;
            end
            if (i_cmd.acc_en) begin
                if (d_sum[36] != d_sum[35])
                    r_cell_d <= d_sum[36] ? {1'b1, 35'd0} : {1'b0, {35{1'b1}}};
                else
                    r_cell_d <= d_sum[35:0];
                if (mx_sum[52] != mx_sum[51])
                    r_cell_mx <= mx_sum[52] ? {1'b1, 51'd0} : {1'b0, {51{1'b1}}};
                else
                    r_cell_mx <= mx_sum[51:0];
                if (my_sum[52] != my_sum[51])
                    r_cell_my <= my_sum[52] ? {1'b1, 51'd0} : {1'b0, {51{1'b1}}};
                else
                    r_cell_my <= my_sum[51:0];
            end
            if (i_cmd.body_add) begin
                if (bd_sum[52] != bd_sum[51])
                    r_body_d <= bd_sum[52] ? {1'b1, 51'd0} : {1'b0, {51{1'b1}}};
                else
                    r_body_d <= bd_sum[51:0];
                if (bx_sum[64] != bx_sum[63])
                    r_body_mx <= bx_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                else
                    r_body_mx <= bx_sum[63:0];
                if (by_sum[64] != by_sum[63])
                    r_body_my <= by_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                else
                    r_body_my <= by_sum[63:0];
            end
            if (i_cmd.cell_clear) begin
                r_inside  <= 1'b0;
                r_cell_d  <= '0;
                r_cell_mx <= '0;
                r_cell_my <= '0;
            end
        end
    end

    // Result setup and centroid capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_setup) begin
            r_den  <= d_ext + (d_ext <<< 1);
            r_area <= d_sel;
            r_zero <= (d_sel == '0);
            r_sat  <= 1'b0;
            r_cx   <= '0;
            r_cy   <= '0;
        end
        if (i_cmd.cap_x) begin
            r_cx  <= div_quo;
            r_sat <= r_sat | div_sat;
        end
        if (i_cmd.cap_y) begin
            r_cy  <= div_quo;
            r_sat <= r_sat | div_sat;
        end
    end

    pmca_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (r_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_sat   (div_sat)
    );

    // Result register
    always_comb begin
        if (r_zero)
            status = pmca_pkg::ST_ZERO;
        else if (r_sat)
            status = pmca_pkg::ST_SAT;
        else
            status = pmca_pkg::ST_OK;
        out_room = !r_o_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_data <= {2'b00, status, r_cy, r_cx, r_area};
            r_o_kind <= i_cmd.kind;
            r_o_last <= i_cmd.last;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;
    assign o_out_kind  = r_o_kind;
    assign o_out_last  = r_o_last;

    assign o_stat.in_cell  = r_inside;
    assign o_stat.close    = r_close;
    assign o_stat.mesh     = r_mesh;
    assign o_stat.d_zero   = r_zero;
    assign o_stat.div_busy = div_busy;
    assign o_stat.div_done = div_done;
    assign o_stat.out_room = out_room;

endmodule

>>> sv/pmca_ctrl.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// pmca_ctrl
// Sequencer: vertex intake, edge steps, divisions and result emission.
// -----------------------------------------------------------------------------
module pmca_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  pmca_pkg::t_stat i_stat,
    output pmca_pkg::t_cmd  o_cmd
);

    pmca_pkg::t_state r_state, n_state;
    logic             r_kind, n_kind;
    logic             r_close_edge, n_close_edge;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= pmca_pkg::S_IDLE;
            r_kind       <= pmca_pkg::KIND_CELL;
            r_close_edge <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_kind       <= n_kind;
            r_close_edge <= n_close_edge;
        end
    end

    // Next state
    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_close_edge = r_close_edge;
        case (r_state)
            pmca_pkg::S_IDLE: begin
                if (i_in_valid) n_state = pmca_pkg::S_OPEN;
            end
            pmca_pkg::S_OPEN: begin
                if (!i_stat.in_cell) begin
                    n_close_edge = 1'b1;
                    n_state      = i_stat.close ? pmca_pkg::S_MUL : pmca_pkg::S_IDLE;
                end else begin
                    n_close_edge = 1'b0;
                    n_state      = pmca_pkg::S_MUL;
                end
            end
            pmca_pkg::S_MUL:   n_state = pmca_pkg::S_CROSS;
            pmca_pkg::S_CROSS: n_state = pmca_pkg::S_MOM;
            pmca_pkg::S_MOM:   n_state = pmca_pkg::S_ACC;
            pmca_pkg::S_ACC: begin
                if (r_close_edge) begin
                    n_state = pmca_pkg::S_RES;
                end else if (i_stat.close) begin
                    n_close_edge = 1'b1;
                    n_state      = pmca_pkg::S_MUL;
                end else begin
                    n_state = pmca_pkg::S_IDLE;
                end
            end
            pmca_pkg::S_RES: n_state = pmca_pkg::S_CHK;
            pmca_pkg::S_CHK: begin
                n_state = i_stat.d_zero ? pmca_pkg::S_EMIT : pmca_pkg::S_DIVX;
            end
            pmca_pkg::S_DIVX: begin
                if (i_stat.div_done) n_state = pmca_pkg::S_DIVY;
            end
            pmca_pkg::S_DIVY: begin
                if (i_stat.div_done) n_state = pmca_pkg::S_EMIT;
            end
            pmca_pkg::S_EMIT: begin
                if (i_stat.out_room) begin
                    if (r_kind == pmca_pkg::KIND_CELL) begin
                        n_state = pmca_pkg::S_BODY;
                    end else begin
                        n_kind  = pmca_pkg::KIND_CELL;
                        n_state = pmca_pkg::S_IDLE;
                    end
                end
            end
            pmca_pkg::S_BODY: begin
                if (i_stat.mesh) begin
                    n_kind  = pmca_pkg::KIND_BODY;
                    n_state = pmca_pkg::S_RES;
                end else begin
                    n_state = pmca_pkg::S_IDLE;
                end
            end
            default: n_state = pmca_pkg::S_IDLE;
        endcase
    end

    // Command outputs
    always_comb begin
        o_cmd            = '0;
        o_cmd.kind       = r_kind;
        o_cmd.last       = (r_kind == pmca_pkg::KIND_BODY) || !i_stat.mesh;
        o_cmd.edge_close = r_close_edge;
        o_in_ready       = 1'b0;
        case (r_state)
            pmca_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            pmca_pkg::S_OPEN: begin
                o_cmd.start_cell = !i_stat.in_cell;
            end
            pmca_pkg::S_MUL:   o_cmd.mul_en   = 1'b1;
            pmca_pkg::S_CROSS: o_cmd.cross_en = 1'b1;
            pmca_pkg::S_MOM:   o_cmd.mom_en   = 1'b1;
            pmca_pkg::S_ACC: begin
                o_cmd.acc_en   = 1'b1;
                o_cmd.set_prev = !r_close_edge;
            end
            pmca_pkg::S_RES: o_cmd.res_setup = 1'b1;
            pmca_pkg::S_CHK: o_cmd.div_start = !i_stat.d_zero;
            pmca_pkg::S_DIVX: begin
                o_cmd.cap_x     = i_stat.div_done;
                o_cmd.div_start = i_stat.div_done;
                o_cmd.div_sel_y = 1'b1;
            end
            pmca_pkg::S_DIVY: o_cmd.cap_y = i_stat.div_done;
            pmca_pkg::S_EMIT: begin
                o_cmd.out_load  = i_stat.out_room;
                o_cmd.all_clear = i_stat.out_room && (r_kind == pmca_pkg::KIND_BODY);
            end
            pmca_pkg::S_BODY: begin
                o_cmd.body_add   = 1'b1;
                o_cmd.cell_clear = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

`ifndef SYNTH
    a_accept_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pmca_pkg::S_IDLE && i_in_valid) |=> (r_state == pmca_pkg::S_OPEN))
        else $error("accepted vertex did not open a step");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> !i_stat.div_busy)
        else $error("divider started while busy");
    a_out_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_stat.out_room)
        else $error("result loaded over a waiting result");
`endif

endmodule

>>> sv/polygon_mesh_centroid_accumulator.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// polygon_mesh_centroid_accumulator
// Shoelace area and centroid of polygon cells and of the whole mesh.
// -----------------------------------------------------------------------------
// Input stream: one vertex per transaction, x in tdata[15:0], y in
// tdata[31:16] (signed Q8.8); tlast marks the last vertex of a cell, tuser
// the last vertex of the mesh (which also closes the open cell).
// Output stream: a cell result at each cell end, followed at a mesh end by a
// body result (tuser = 1). tlast marks the final result of a vertex.
// Sequence: the first vertex of a cell only opens it; a further vertex runs
// the multiply, cross, moment and accumulate steps. A closing vertex adds a
// closing edge and a result, set by the shared 64-step divider run twice (x
// and y); with zero area the divisions are skipped. A mesh end adds a second result.
// One vertex is worked on at a time; s_axis_tready is high only when idle.
// The result waits in an output register; a stalled receiver holds the
// sequencer before the next result is written, never losing one.
// Reset (synchronous, active low) clears all cell and body sums and drops
// any pending result.
// -----------------------------------------------------------------------------
module polygon_mesh_centroid_accumulator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // vertex_x[15:0], vertex_y[31:16]
    input  logic        s_axis_tlast,   // cell_end
    input  logic        s_axis_tuser,   // mesh_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // area[51:0], centroid_x[67:52],
                                        // centroid_y[83:68], status[85:84], zero pad
    output logic        m_axis_tlast,   // last
    output logic        m_axis_tuser    // kind
);

    pmca_pkg::t_cmd  cmd;
    pmca_pkg::t_stat stat;

    pmca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pmca_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_in_data     (s_axis_tdata),
        .i_in_cell_end (s_axis_tlast),
        .i_in_mesh_end (s_axis_tuser),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_data    (m_axis_tdata),
        .o_out_kind    (m_axis_tuser),
        .o_out_last    (m_axis_tlast)
    );

endmodule
